### rtl/mcg_pkg.sv
// Shared types and constants of the mask candidate generator.
`timescale 1ns / 1ps
package mcg_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned SIZE_W   = 9;
  localparam int unsigned NCHARS   = 256;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 7;
  // quotient bits resolved per divider cycle
  localparam int unsigned DIV_STEP = 4;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_GEN   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POSITIONS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLD      = 1'd1;

  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0]        kind;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  last_idx;
  } cmd_t;

endpackage

### rtl/mcg_front.sv
// Front end: configuration registers, item classification and case folding.
`timescale 1ns / 1ps
module mcg_front #(
  parameter int unsigned MAX_POSITIONS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mcg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mcg_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     kind_i,
  input  logic [mcg_pkg::POS_W-1:0]      position_i,
  input  logic [mcg_pkg::CHAR_W-1:0]     char_code_i,
  input  logic [mcg_pkg::KEY_W-1:0]      key_index_i,
  output logic                           push_o,
  output mcg_pkg::cmd_t                  cmd_o,
  input  logic                           full_i
);
  import mcg_pkg::*;

  logic [CNT_W-1:0]  pos_use_q;
  logic              fold_q;
  logic [CNT_W-1:0]  n_sat;
  logic [CHAR_W-1:0] ch_fold;
  logic              pos_ok;
  logic              drop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_use_q <= CNT_W'(1);
      fold_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_POSITIONS: pos_use_q <= cfg_data_i[CNT_W-1:0];
        CFG_FOLD:      fold_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pos_use_q == '0) n_sat = CNT_W'(1);
    else if (pos_use_q > CNT_W'(MAX_POSITIONS)) n_sat = CNT_W'(MAX_POSITIONS);
    else n_sat = pos_use_q;
    if (fold_q && char_code_i >= CHAR_LOWER_A && char_code_i <= CHAR_LOWER_Z)
      ch_fold = char_code_i - CASE_OFFSET;
    else
      ch_fold = char_code_i;
  end

  assign pos_ok = {1'b0, position_i} < CNT_W'(MAX_POSITIONS);
  // drop unknown kinds and clear/add to out-of-range positions without a result
  assign drop   = ((kind_i != KIND_CLEAR) && (kind_i != KIND_ADD) && (kind_i != KIND_GEN)) ||
                  ((kind_i != KIND_GEN) && !pos_ok);

  assign in_ready_o      = !full_i;
  assign push_o          = in_valid_i && !full_i && !drop;
  assign cmd_o.kind      = kind_i;
  assign cmd_o.pos       = position_i;
  assign cmd_o.ch        = ch_fold;
  assign cmd_o.key       = key_index_i;
  assign cmd_o.last_idx  = POS_W'(n_sat - CNT_W'(1));

endmodule

### rtl/mcg_queue.sv
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
module mcg_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mcg_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output mcg_pkg::cmd_t cmd_o
);
  import mcg_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign cmd_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");

endmodule

### rtl/mcg_div.sv
// Iterative 64-bit by 9-bit divider, several quotient bits per cycle.
`timescale 1ns / 1ps
module mcg_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mcg_pkg::KEY_W-1:0]    dividend_i,
  input  logic [mcg_pkg::SIZE_W-1:0]   divisor_i,
  output logic                         busy_o,
  output logic [mcg_pkg::KEY_W-1:0]    quot_o,
  output logic [mcg_pkg::SIZE_W-1:0]   rem_o
);
  import mcg_pkg::*;

  localparam int unsigned ROUNDS = KEY_W / DIV_STEP;
  localparam int unsigned RW     = $clog2(ROUNDS);

  logic [KEY_W-1:0]  quot_q, quot_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [SIZE_W-1:0] dsr_q;
  logic [RW-1:0]     cnt_q;
  logic              busy_q;
  logic [SIZE_W:0]   trial;

  // shift dividend bits out of the top, quotient bits into the bottom
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    trial  = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      trial  = {rem_d, quot_d[KEY_W-1]};
      quot_d = {quot_d[KEY_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        trial     = trial - {1'b0, dsr_q};
        quot_d[0] = 1'b1;
      end
      rem_d = trial[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + RW'(1);
      if (cnt_q == RW'(ROUNDS - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

### rtl/mcg_back.sv
// Back end: set storage, generate sequencer and output register.
`timescale 1ns / 1ps
module mcg_back #(
  parameter int unsigned MAX_POSITIONS = 64,
  parameter int unsigned SET_ENTRIES   = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        pop_o,
  input  mcg_pkg::cmd_t               cmd_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mcg_pkg::CHAR_W-1:0]  out_char_o,
  output logic [mcg_pkg::POS_W-1:0]   out_position_o,
  output logic                        last_o,
  output logic [1:0]                  status_o
);
  import mcg_pkg::*;

  localparam int unsigned PW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int unsigned EW = $clog2(SET_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EXEC, S_DIV, S_CRD, S_CEMIT, S_OUT
  } state_e;

  typedef struct packed {
    logic [NCHARS-1:0] pres;
    logic [SIZE_W-1:0] size;
  } row_t;

  state_e            state_q;
  cmd_t              cmd_q;
  logic [POS_W-1:0]  idx_q;
  logic [KEY_W-1:0]  val_q;
  logic [MAX_POSITIONS-1:0] row_vld_q;
  row_t              rows_q [MAX_POSITIONS];
  logic [CHAR_W-1:0] chars_q [MAX_POSITIONS][SET_ENTRIES];
  row_t              rd_row_q;
  logic              rd_vld_q;
  logic [CHAR_W-1:0] rd_chr_q;
  logic              out_valid_q;
  logic [CHAR_W-1:0] out_char_q;
  logic [POS_W-1:0]  out_pos_q;
  logic              last_q;
  logic [1:0]        status_q;

  logic [PW-1:0]     ridx;
  row_t              cur_row;
  logic              is_dup;
  logic              row_we;
  logic              div_start;
  logic              div_busy;
  logic [KEY_W-1:0]  div_quot;
  logic [SIZE_W-1:0] div_rem;
  logic [EW-1:0]     ent;
  logic              gen_last;

  assign ridx    = idx_q[PW-1:0];
  assign cur_row = rd_vld_q ? rd_row_q : '0;
  assign is_dup  = cur_row.pres[cmd_q.ch] || (cur_row.size >= SIZE_W'(SET_ENTRIES));
  assign row_we  = (state_q == S_EXEC) && (cmd_q.kind == KIND_ADD) && !is_dup;
  assign div_start = (state_q == S_EXEC) && (cmd_q.kind == KIND_GEN) &&
                     (cur_row.size != '0);
  assign ent      = EW'(div_rem & SIZE_W'(SET_ENTRIES - 1));
  assign gen_last = idx_q == cmd_q.last_idx;
  assign pop_o    = (state_q == S_IDLE) && cmd_valid_i;

  mcg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (val_q),
    .divisor_i  (cur_row.size),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // row store: presence bits and fill count of each position
  always_ff @(posedge clk_i) begin
    rd_row_q <= rows_q[ridx];
    if (row_we) begin
      rows_q[ridx].pres <= cur_row.pres | (NCHARS'(1) << cmd_q.ch);
      rows_q[ridx].size <= cur_row.size + SIZE_W'(1);
    end
  end

  // character store
  always_ff @(posedge clk_i) begin
    rd_chr_q <= chars_q[ridx][ent];
    if (row_we) chars_q[ridx][cur_row.size[EW-1:0]] <= cmd_q.ch;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cmd_q       <= '0;
      idx_q       <= '0;
      val_q       <= '0;
      out_char_q  <= '0;
      out_pos_q   <= '0;
      last_q      <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      rd_vld_q <= row_vld_q[ridx];
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            val_q <= cmd_i.key;
            idx_q <= (cmd_i.kind == KIND_GEN) ? '0 : cmd_i.pos;
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_EXEC;
        S_EXEC: begin
          out_char_q <= '0;
          out_pos_q  <= idx_q;
          case (cmd_q.kind)
            KIND_CLEAR: begin
              row_vld_q[ridx] <= 1'b0;
              last_q   <= 1'b1;
              status_q <= ST_OK;
              state_q  <= S_OUT;
            end
            KIND_ADD: begin
              last_q  <= 1'b1;
              state_q <= S_OUT;
              if (is_dup) begin
                status_q <= ST_DUP;
              end else begin
                status_q        <= ST_OK;
                row_vld_q[ridx] <= 1'b1;
              end
            end
            default: begin
              last_q <= gen_last;
              if (cur_row.size == '0) begin
                status_q <= ST_EMPTY;
                state_q  <= S_OUT;
              end else begin
                status_q <= ST_OK;
                state_q  <= S_DIV;
              end
            end
          endcase
        end
        S_DIV: if (!div_busy) state_q <= S_CRD;
        S_CRD: state_q <= S_CEMIT;
        S_CEMIT: begin
          out_char_q <= rd_chr_q;
          val_q      <= div_quot;
          state_q    <= S_OUT;
        end
        S_OUT: begin
          if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
            if (cmd_q.kind == KIND_GEN && !last_q) begin
              idx_q   <= idx_q + POS_W'(1);
              state_q <= S_RD;
            end else begin
              state_q <= S_IDLE;
            end
          end else begin
            out_valid_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_char_o     = out_char_q;
  assign out_position_o = out_pos_q;
  assign last_o         = last_q;
  assign status_o       = status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == S_OUT)
    else $error("result shown outside output state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_EMPTY) |-> out_char_q == '0)
    else $error("empty position gave a character");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_busy)
    else $error("divider did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && cmd_q.kind != KIND_GEN) |-> last_q)
    else $error("clear or add result without last");

endmodule

### rtl/mask_candidate_generator_unit.sv
// Top level of the mask candidate generator.
`timescale 1ns / 1ps
// Keeps a deduplicated character set per mask position and turns a 64-bit
// keyspace index into one candidate character per position, least significant
// position first (mixed radix). Once the back takes a transaction from the
// queue, a clear or add result goes through a row read, an execute step and
// the output state, where it waits until accepted. A generate transaction is
// taken once and then visits each position: a non-empty one goes through a
// row read, an execute step, a wait on the divider (rounds of four quotient
// bits), a character read, a capture step and the output state. An empty
// position goes through a row read, an execute step and the output state.
// The front accepts and classifies transactions into a two-entry queue while
// the back works, so input can run ahead of a stalled output. Unknown kinds
// and clear/add to positions beyond MAX_POSITIONS are accepted and dropped
// without a result. Configuration writes are always ready and must be issued
// only while the block is idle.
module mask_candidate_generator_unit #(
  parameter int unsigned MAX_POSITIONS = 64,
  parameter int unsigned SET_ENTRIES   = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mcg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mcg_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     kind_i,
  input  logic [mcg_pkg::POS_W-1:0]      position_i,
  input  logic [mcg_pkg::CHAR_W-1:0]     char_code_i,
  input  logic [mcg_pkg::KEY_W-1:0]      key_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mcg_pkg::CHAR_W-1:0]     out_char_o,
  output logic [mcg_pkg::POS_W-1:0]      out_position_o,
  output logic                           last_o,
  output logic [1:0]                     status_o
);
  import mcg_pkg::*;

  logic push, full, q_valid, pop;
  cmd_t front_cmd, q_cmd;

  // classify and fold at the front
  mcg_front #(.MAX_POSITIONS(MAX_POSITIONS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .position_i  (position_i),
    .char_code_i (char_code_i),
    .key_index_i (key_index_i),
    .push_o      (push),
    .cmd_o       (front_cmd),
    .full_i      (full)
  );

  // decouple front and back
  mcg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .cmd_o   (q_cmd)
  );

  // execute against set storage
  mcg_back #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .SET_ENTRIES   (SET_ENTRIES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .pop_o          (pop),
    .cmd_i          (q_cmd),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_char_o     (out_char_o),
    .out_position_o (out_position_o),
    .last_o         (last_o),
    .status_o       (status_o)
  );

endmodule

### sim/mask_candidate_generator_unit_test.sv
// Self-checking testbench for the mask candidate generator top level.
`timescale 1ns / 1ps
// Drive clear, add and generate transactions through the input channel and
// predict every result with a behavioral copy of the position sets.
// - Keep per-position character lists, sizes and a presence map here.
// - Push the predicted results of each accepted transaction on a queue.
// - Pop and compare each accepted output transaction field by field.
// Walk the register through several settings, including zero and the
// largest value, which the block saturates. Add random idle bursts on
// both channels, then finish with a stretch that has no idling.
module mask_candidate_generator_unit_test;
  import mcg_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
    logic              last;
    logic [1:0]        status;
  } cand_t;

  localparam int unsigned NPOS  = 64;
  localparam int unsigned NSET  = 256;
  localparam logic [1:0]  KIND_NONE = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DAT_W-1:0]  cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [1:0]            kind_i;
  logic [POS_W-1:0]      position_i;
  logic [CHAR_W-1:0]     char_code_i;
  logic [KEY_W-1:0]      key_index_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [CHAR_W-1:0]     out_char_o;
  logic [POS_W-1:0]      out_position_o;
  logic                  last_o;
  logic [1:0]            status_o;

  // predictor state
  logic [CHAR_W-1:0]     set_list [NPOS][NSET];
  int unsigned           set_len  [NPOS];
  logic [NPOS-1:0]       char_seen [NCHARS];
  logic [CNT_W-1:0]      cfg_positions;
  logic                  cfg_fold;

  cand_t                 cand_q [$];
  int unsigned           n_errors;
  int unsigned           n_items;
  int unsigned           n_results;
  bit                    idling;
  int unsigned           out_hold;

  mask_candidate_generator_unit u_top (.*);

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Apply one accepted transaction to the predictor and queue its results.
  task automatic predict_transaction(input logic [1:0] kind, input logic [POS_W-1:0] pos,
                                     input logic [CHAR_W-1:0] ch, input logic [KEY_W-1:0] key);
    cand_t       r;
    int unsigned n;
    int unsigned len;
    logic [CHAR_W-1:0] c;
    r = '0;
    r.pos  = pos;
    r.last = 1'b1;
    r.status = ST_OK;
    case (kind)
      KIND_CLEAR: begin
        set_len[pos] = 0;
        for (int i = 0; i < NCHARS; i++) char_seen[i][pos] = 1'b0;
        cand_q.push_back(r);
      end
      KIND_ADD: begin
        c = ch;
        if (cfg_fold && c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) c = c - CASE_OFFSET;
        if (char_seen[c][pos] || set_len[pos] >= NSET) begin
          r.status = ST_DUP;
        end else begin
          char_seen[c][pos] = 1'b1;
          set_list[pos][set_len[pos]] = c;
          set_len[pos]++;
        end
        cand_q.push_back(r);
      end
      KIND_GEN: begin
        n = cfg_positions;
        if (n < 1) n = 1;
        if (n > NPOS) n = NPOS;
        for (int i = 0; i < n; i++) begin
          len = set_len[i];
          r.pos  = i;
          r.last = (i + 1 == n);
          if (len == 0) begin
            r.ch = '0;
            r.status = ST_EMPTY;
          end else begin
            r.ch = set_list[i][key % len];
            r.status = ST_OK;
            key = key / len;
          end
          cand_q.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // Send one transaction; hold valid and payload until accepted. Valid stays
  // high into the next transaction unless an idle burst or a drain drops it.
  task automatic send_item(input logic [1:0] kind, input logic [POS_W-1:0] pos,
                           input logic [CHAR_W-1:0] ch, input logic [KEY_W-1:0] key);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    position_i  <= pos;
    char_code_i <= ch;
    key_index_i <= key;
    do @(posedge clk_i); while (!in_ready_o);
    predict_transaction(kind, pos, ch, key);
    n_items++;
    @(negedge clk_i);
  endtask

  // Drain everything in flight, then write one register.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    in_valid_i <= 1'b0;
    wait (cand_q.size() == 0);
    // dropped transactions give no result; let them leave the pipeline
    repeat (64) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_POSITIONS) cfg_positions = val;
    else cfg_fold = val[0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return KEY_W'($urandom_range(0, 300));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_empty_sets();
    send_item(KIND_GEN, 6'd0, 8'd0, '1);
    write_register(CFG_POSITIONS, 7'd3);
    send_item(KIND_GEN, 6'd0, 8'd0, 64'd5);
  endtask

  task automatic test_set_building();
    send_item(KIND_ADD, 6'd0, 8'h00, '0);
    send_item(KIND_ADD, 6'd0, 8'hff, '0);
    send_item(KIND_ADD, 6'd0, 8'h00, '0);      // duplicate
    send_item(KIND_ADD, 6'd2, 8'h41, '0);
    send_item(KIND_ADD, 6'd2, 8'h61, '0);      // distinct while folding is off
    send_item(KIND_ADD, 6'd63, 8'h55, '0);
    send_item(KIND_NONE, 6'd1, 8'h33, '1);     // unknown kind, no result
    send_item(KIND_GEN, 6'd0, 8'h00, 64'd1);   // middle position stays empty
    send_item(KIND_GEN, 6'd0, 8'h00, '1);
    send_item(KIND_CLEAR, 6'd0, 8'h00, '0);
    send_item(KIND_GEN, 6'd0, 8'h00, 64'd3);
    send_item(KIND_ADD, 6'd0, 8'h7a, '0);
  endtask

  task automatic test_case_folding();
    write_register(CFG_FOLD, 7'd1);
    send_item(KIND_ADD, 6'd1, 8'h61, '0);      // becomes upper case
    send_item(KIND_ADD, 6'd1, 8'h41, '0);      // now a duplicate
    send_item(KIND_ADD, 6'd1, 8'h7a, '0);
    send_item(KIND_ADD, 6'd1, 8'h60, '0);      // just below the letters
    send_item(KIND_ADD, 6'd1, 8'h7b, '0);      // just above
    send_item(KIND_GEN, 6'd0, 8'h00, 64'd7);
    write_register(CFG_FOLD, 7'd0);
  endtask

  // Fill one position completely so the divide by 256 is exercised.
  task automatic test_full_set();
    write_register(CFG_FOLD, 7'd0);
    send_item(KIND_CLEAR, 6'd3, 8'h00, '0);
    for (int c = 0; c < NSET; c++) send_item(KIND_ADD, 6'd3, 8'(c ^ 8'h5a), '0);
    send_item(KIND_ADD, 6'd3, 8'h10, '0);      // full, reported as a duplicate
    write_register(CFG_POSITIONS, 7'd4);
    for (int k = 0; k < 4; k++) send_item(KIND_GEN, 6'd0, 8'h00, rand_key());
  endtask

  task automatic test_saturation();
    write_register(CFG_POSITIONS, 7'd64);
    send_item(KIND_GEN, 6'd0, 8'h00, '1);
    write_register(CFG_POSITIONS, 7'd127);
    send_item(KIND_GEN, 6'd0, 8'h00, {$urandom, $urandom});
    write_register(CFG_POSITIONS, 7'd0);
    send_item(KIND_GEN, 6'd0, 8'h00, 64'd2);
  endtask

  // Random mix; adds favor positions that generates actually walk.
  task automatic test_random_mix(input int unsigned count);
    int unsigned sel;
    int unsigned span;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        write_register(CFG_POSITIONS, CFG_DAT_W'($urandom_range(1, 6)));
        write_register(CFG_FOLD, CFG_DAT_W'($urandom_range(0, 1)));
      end
      span = cfg_positions + 1;
      sel  = $urandom_range(0, 99);
      if (sel < 45) begin
        send_item(KIND_ADD,
                  ($urandom_range(0, 9) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(0, span)),
                  ($urandom_range(0, 1) == 0) ? CHAR_W'($urandom_range(8'h5e, 8'h7e))
                                              : CHAR_W'($urandom), '0);
      end else if (sel < 52) begin
        send_item(KIND_CLEAR, POS_W'($urandom_range(0, span)), CHAR_W'($urandom), rand_key());
      end else if (sel < 95) begin
        send_item(KIND_GEN, POS_W'($urandom), CHAR_W'($urandom), rand_key());
      end else begin
        send_item(KIND_NONE, POS_W'($urandom), CHAR_W'($urandom), rand_key());
      end
    end
  endtask

  // Stall the output in random bursts while idling is enabled.
  always @(negedge clk_i) begin
    if (!idling) begin
      out_ready_i <= 1'b1;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      out_hold <= $urandom_range(0, 10);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare every accepted output transaction with the oldest prediction.
  always @(posedge clk_i) begin
    cand_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (cand_q.size() == 0) begin
        $display("%0t: unexpected output char %h pos %0d last %b status %0d",
                 $time, out_char_o, out_position_o, last_o, status_o);
        n_errors++;
      end else begin
        want = cand_q.pop_front();
        if (out_char_o !== want.ch) begin
          $display("%0t: out_char expected %h actual %h", $time, want.ch, out_char_o);
          n_errors++;
        end
        if (out_position_o !== want.pos) begin
          $display("%0t: out_position expected %0d actual %0d", $time, want.pos, out_position_o);
          n_errors++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, last_o);
          n_errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, cand_q.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    kind_i      = '0;
    position_i  = '0;
    char_code_i = '0;
    key_index_i = '0;
    out_ready_i = 1'b1;
    out_hold    = 0;
    n_errors    = 0;
    n_items     = 0;
    n_results   = 0;
    idling      = 1'b1;
    cfg_positions = 7'd1;
    cfg_fold    = 1'b0;
    for (int p = 0; p < NPOS; p++) set_len[p] = 0;
    for (int c = 0; c < NCHARS; c++) char_seen[c] = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_sets();
    test_set_building();
    test_case_folding();
    test_saturation();
    test_random_mix(8);
    idling = 1'b0;
    test_full_set();
    test_random_mix(4);

    in_valid_i <= 1'b0;
    wait (cand_q.size() == 0);
    repeat (200) @(negedge clk_i);
    $display("Covered %0d input transactions and %0d output transactions,", n_items, n_results);
    $display("including folding, full and empty sets and saturated position counts.");
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
